[design/ngfe_pkg.sv]
// Package for the NMEA GGA field extractor.
// Holds result kind codes, protocol constants and the default-string and comma-skip tables.
// No dependencies.
package ngfe_pkg;

   localparam int MAX_FIELD_LEN_DEF = 16;
   localparam int FIELD_COUNT_DEF   = 5;

   localparam int TAG_LEN   = 5;
   localparam int TAG_W     = 40;
   localparam int CSR_DW    = 64;
   localparam int CSR_AW    = 4;

   localparam logic [TAG_W-1:0] TAG_RESET = 40'h47_4E_47_47_41;   // "GNGGA"
   localparam logic [7:0]       COMMA     = 8'h2C;
   localparam logic [7:0]       CH_ZERO   = 8'h30;
   localparam logic [7:0]       CH_DOT    = 8'h2E;
   localparam logic [7:0]       CH_M      = 8'h4D;

   // register index decoded from paddr[3]
   localparam logic REG_SENTENCE_TAG = 1'b0;

   typedef enum logic [1:0] {
      KIND_CHAR = 2'd0,
      KIND_END  = 2'd1,
      KIND_DONE = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [2:0] field_index;
      logic [3:0] char_position;
      logic [7:0] char_value;
      logic       overflow;
      logic       last;
   } result_type;

   // commas still to skip once a field closes
   function automatic logic [2:0] skip_after(input logic [2:0] f);
      logic [2:0] n;
      unique case (f)
         3'd1:    n = 3'd1;
         3'd2:    n = 3'd4;
         default: n = 3'd0;
      endcase
      return n;
   endfunction

   function automatic logic [3:0] default_len(input logic [2:0] f);
      logic [3:0] n;
      unique case (f)
         3'd0:    n = 4'd9;
         3'd1:    n = 4'd10;
         3'd2:    n = 4'd11;
         3'd3:    n = 4'd4;
         3'd4:    n = 4'd1;
         default: n = 4'd0;
      endcase
      return n;
   endfunction

   // digits everywhere except the decimal point and the units letter
   function automatic logic [7:0] default_char(input logic [2:0] f, input logic [3:0] i);
      logic [7:0] c;
      c = CH_ZERO;
      unique case (f)
         3'd0:    if (i == 4'd6) c = CH_DOT;
         3'd1:    if (i == 4'd4) c = CH_DOT;
         3'd2:    if (i == 4'd5) c = CH_DOT;
         3'd3:    if (i == 4'd2) c = CH_DOT;
         3'd4:    c = CH_M;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

[design/ngfe_req_if.sv]
// Input byte channel for the NMEA GGA field extractor.
// Valid/ready handshake carrying one received byte; no dependencies.
interface ngfe_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

[design/ngfe_rsp_if.sv]
// Result channel for the NMEA GGA field extractor.
// Valid/ready handshake carrying one extracted character or marker; no dependencies.
interface ngfe_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [2:0] field_index;
   logic [3:0] char_position;
   logic [7:0] char_value;
   logic       overflow;
   logic       last;

   modport source (output valid, output kind, output field_index, output char_position,
                   output char_value, output overflow, output last, input ready);
   modport sink   (input valid, input kind, input field_index, input char_position,
                   input char_value, input overflow, input last, output ready);
endinterface

[design/ngfe_parser.sv]
// Sentence parser: tag hunt, comma skipping, field capture and default-string runs.
// Depends on ngfe_pkg, ngfe_req_if and ngfe_rsp_if.
module ngfe_parser #(
   parameter int MAX_FIELD_LEN = ngfe_pkg::MAX_FIELD_LEN_DEF,
   parameter int FIELD_COUNT   = ngfe_pkg::FIELD_COUNT_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [ngfe_pkg::TAG_W-1:0]   sentence_tag,
   ngfe_req_if.sink                     req_chan,
   ngfe_rsp_if.source                   rsp_chan
);
   import ngfe_pkg::*;

   localparam int PW = $clog2(MAX_FIELD_LEN + 1);
   localparam int FW = $clog2(FIELD_COUNT + 1);
   localparam logic [3:0] OVF_POS = 4'(MAX_FIELD_LEN - 1);

   logic [2:0]    skip_ff, skip_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [FW-1:0] field_ff, field_in;
   logic          found_ff, found_in;

   logic          run_ff, run_in;
   logic [2:0]    run_field_ff, run_field_in;
   logic [3:0]    run_idx_ff, run_idx_in;

   logic          out_valid_ff, out_valid_in;
   result_type    out_ff, out_in;

   logic          out_free, accept, emit, start_run;
   logic [7:0]    b;
   logic [2:0]    f;
   logic [3:0]    len;
   logic [7:0]    want;
   logic          want_ok;
   result_type    res, run_res;
   logic [3:0]    run_len;

   assign out_free       = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !run_ff && out_free;
   assign accept         = req_chan.valid && req_chan.ready;
   assign b              = req_chan.rx_byte;
   assign f              = 3'(field_ff);
   assign len            = default_len(f);
   assign run_len        = default_len(run_field_ff);

   // expected tag character at the current match position
   always_comb begin
      want_ok = 1'b1;
      unique case (pos_ff)
         PW'(0):  want = sentence_tag[39:32];
         PW'(1):  want = sentence_tag[31:24];
         PW'(2):  want = sentence_tag[23:16];
         PW'(3):  want = sentence_tag[15:8];
         PW'(4):  want = sentence_tag[7:0];
         default: begin
            want    = 8'h00;
            want_ok = 1'b0;
         end
      endcase
   end

   always_comb begin
      skip_in   = skip_ff;
      pos_in    = pos_ff;
      field_in  = field_ff;
      found_in  = found_ff;
      emit      = 1'b0;
      start_run = 1'b0;
      res       = '{kind: KIND_CHAR, field_index: f, char_position: 4'd0,
                    char_value: 8'h00, overflow: 1'b0, last: 1'b1};
      priority if (found_ff && (field_ff >= FW'(FIELD_COUNT))) begin
         emit             = 1'b1;
         res.kind         = KIND_DONE;
         res.field_index  = 3'd0;
         field_in         = '0;
         found_in         = 1'b0;
         pos_in           = '0;
         skip_in          = 3'd0;
      end else if (skip_ff != 3'd0) begin
         if (b == COMMA) skip_in = skip_ff - 3'd1;
      end else if (found_ff) begin
         if (b == COMMA) begin
            emit     = 1'b1;
            skip_in  = skip_after(f);
            field_in = field_ff + FW'(1);
            pos_in   = '0;
            if (pos_ff != '0) begin
               res.kind          = KIND_END;
               res.char_position = pos_ff[3:0];
            end else if (len == 4'd0) begin
               res.kind = KIND_END;
            end else begin
               // first default character now, the rest from the run generator
               res.char_value = default_char(f, 4'd0);
               res.last       = 1'b0;
               start_run      = 1'b1;
            end
         end else if (pos_ff < PW'(MAX_FIELD_LEN)) begin
            emit              = 1'b1;
            res.char_position = pos_ff[3:0];
            res.char_value    = b;
            pos_in            = pos_ff + PW'(1);
         end else begin
            emit              = 1'b1;
            res.char_position = OVF_POS;
            res.char_value    = b;
            res.overflow      = 1'b1;
         end
      end else begin
         if (want_ok && (b == want)) begin
            if (pos_ff == PW'(TAG_LEN - 1)) begin
               skip_in  = 3'd1;
               found_in = 1'b1;
               pos_in   = '0;
            end else begin
               pos_in = pos_ff + PW'(1);
            end
         end else begin
            pos_in = '0;
         end
      end
   end

   // default-string run: remaining characters, then the field end
   always_comb begin
      run_res = '{kind: KIND_CHAR, field_index: run_field_ff, char_position: run_idx_ff,
                  char_value: default_char(run_field_ff, run_idx_ff), overflow: 1'b0,
                  last: 1'b0};
      if (run_idx_ff >= run_len) begin
         run_res.kind       = KIND_END;
         run_res.char_value = 8'h00;
         run_res.last       = 1'b1;
      end
   end

   always_comb begin
      run_in       = run_ff;
      run_field_in = run_field_ff;
      run_idx_in   = run_idx_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      out_in       = out_ff;
      priority if (run_ff && out_free) begin
         out_valid_in = 1'b1;
         out_in       = run_res;
         run_idx_in   = run_idx_ff + 4'd1;
         if (run_res.kind == KIND_END) run_in = 1'b0;
      end else if (accept && emit) begin
         out_valid_in = 1'b1;
         out_in       = res;
         if (start_run) begin
            run_in       = 1'b1;
            run_field_in = f;
            run_idx_in   = 4'd1;
         end
      end else begin
         // hold
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff      <= 3'd0;
         pos_ff       <= '0;
         field_ff     <= '0;
         found_ff     <= 1'b0;
         run_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            skip_ff  <= skip_in;
            pos_ff   <= pos_in;
            field_ff <= field_in;
            found_ff <= found_in;
         end
         run_ff       <= run_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      run_field_ff <= run_field_in;
      run_idx_ff   <= run_idx_in;
      out_ff       <= out_in;
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.kind          = out_ff.kind;
   assign rsp_chan.field_index   = out_ff.field_index;
   assign rsp_chan.char_position = out_ff.char_position;
   assign rsp_chan.char_value    = out_ff.char_value;
   assign rsp_chan.overflow      = out_ff.overflow;
   assign rsp_chan.last          = out_ff.last;

endmodule

[design/nmea_gga_field_extractor_top.sv]
// Top level of the NMEA GGA field extractor: sentence-tag register on an APB-style port
// and the parser. Depends on ngfe_pkg, ngfe_req_if, ngfe_rsp_if and ngfe_parser.
//
//   channel    direction  handshake        payload
//   req_chan   in         valid/ready      rx_byte[7:0]
//   rsp_chan   out        valid/ready      kind, field_index, char_position, char_value,
//                                          overflow, last
//   APB        in         psel/penable     paddr[3:0], pwdata[63:0] -> sentence_tag (8*i)
//
// A byte is taken every cycle unless rsp_chan stalls or a default-string run is active;
// its result lands in the output register the next cycle. An empty field's default
// string (up to 11 characters plus the field end) holds off req_chan.ready till the run ends.
// Reset is synchronous and returns the parser to the tag hunt with the tag "GNGGA".
// rsp_chan stalls back up into req_chan.ready in the same cycle.
module nmea_gga_field_extractor_top #(
   parameter int MAX_FIELD_LEN = ngfe_pkg::MAX_FIELD_LEN_DEF,
   parameter int FIELD_COUNT   = ngfe_pkg::FIELD_COUNT_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   ngfe_req_if.sink                     req_chan,
   ngfe_rsp_if.source                   rsp_chan,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [ngfe_pkg::CSR_AW-1:0]  paddr,
   input  logic [ngfe_pkg::CSR_DW-1:0]  pwdata,
   output logic [ngfe_pkg::CSR_DW-1:0]  prdata,
   output logic                         pready
);
   import ngfe_pkg::*;

   logic [TAG_W-1:0] tag_ff;
   logic             wr;

   assign pready = 1'b1;
   assign wr     = psel && penable && pwrite && (paddr[3] == REG_SENTENCE_TAG);

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= TAG_RESET;
      end else if (wr) begin
         tag_ff <= pwdata[TAG_W-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[3] == REG_SENTENCE_TAG) prdata = {{(CSR_DW-TAG_W){1'b0}}, tag_ff};
   end

   ngfe_parser #(
      .MAX_FIELD_LEN (MAX_FIELD_LEN),
      .FIELD_COUNT   (FIELD_COUNT)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .sentence_tag (tag_ff),
      .req_chan     (req_chan),
      .rsp_chan     (rsp_chan)
   );

endmodule
